>>> design/multi_bin_dft_accumulator_defines.svh
// Assertion macros shared by the multi-bin DFT accumulator RTL
`ifndef MULTI_BIN_DFT_ACCUMULATOR_DEFINES_SVH
`define MULTI_BIN_DFT_ACCUMULATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MBDFT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mbdft assertion failed");

// Check a property on every clock edge, reset included.
`define MBDFT_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("mbdft assertion failed");

`endif

>>> design/mbdft_pkg.sv
// Package: constants, types and sine table of the multi-bin DFT accumulator
`timescale 1ns / 1ps
`default_nettype none
package mbdft_pkg;

	localparam int NUM_FREQ        = 16;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;
	localparam int IDX_W           = (NUM_FREQ > 1) ? $clog2(NUM_FREQ) : 1;
	localparam int CELL_LAT        = 4;
	localparam int QW              = 49;
	localparam int TERM_W          = 54;
	localparam int ACC_W           = 48;
	localparam int DRAIN_W         = $clog2(NUM_FREQ + CELL_LAT + 1);
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	localparam logic OUT_TD  = 1'b0;
	localparam logic OUT_BIN = 1'b1;

	localparam logic [2:0] CFG_ENABLE    = 3'd0;
	localparam logic [2:0] CFG_WEIGHT    = 3'd1;
	localparam logic [2:0] CFG_TD_INTVL  = 3'd2;
	localparam logic [2:0] CFG_FD_INTVL  = 3'd3;
	localparam logic [2:0] CFG_BIN_SCALE = 3'd4;
	localparam logic [2:0] CFG_NUM_FREQS = 3'd5;

	// Sample token handed from cell to cell
	typedef struct packed {
		logic                 valid;
		logic signed [QW-1:0] q;
		logic [31:0]          t;
	} tok_t;

	typedef logic [14:0] sine_tab_t [0:QUARTER_LEN];

	// Quarter-wave sine in unsigned Q0.15, Taylor series in Q30, evaluated at elaboration
	function automatic sine_tab_t build_sine();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		longint      r;
		for (int k = 0; k <= QUARTER_LEN; k++) begin
			x    = (64'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
			term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
			term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
			if (sum < 0)
				sum = 0;
			r = (sum + 64'sd16384) >>> 15;
			if (r > 32767)
				r = 32767;
			tab[k] = 15'(r);
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine();

endpackage
`default_nettype wire

>>> design/mbdft_mod.sv
// Bit-serial remainder unit: 32-bit dividend modulo 16-bit divisor
`timescale 1ns / 1ps
`default_nettype none
module mbdft_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] rem
);

	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					done_q <= 1'b1;
			end
		end
	end

	// shift one dividend bit in, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != 6'd0) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

>>> design/mbdft_cell.sv
// One bin cell: frequency word, phase, sine lookup, rotate and saturating accumulate
`timescale 1ns / 1ps
`default_nettype none
module mbdft_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               act,
	input  logic                               ld_en,
	input  logic [31:0]                        ld_freq,
	input  logic                               clr,
	input  mbdft_pkg::tok_t                    tok_in,
	output mbdft_pkg::tok_t                    tok_out,
	output logic signed [mbdft_pkg::ACC_W-1:0] acc_re,
	output logic signed [mbdft_pkg::ACC_W-1:0] acc_im
);

	localparam int B = mbdft_pkg::SINE_TABLE_BITS;

	logic [31:0]                         freq_q;
	mbdft_pkg::tok_t                     tok_q;
	logic                                v_s1, v_s2, v_s3;
	logic [31:0]                         ph_s1;
	logic signed [mbdft_pkg::QW-1:0]     q_s1, q_s2;
	logic [14:0]                         smag_s2, cmag_s2;
	logic                                sneg_s2, cneg_s2;
	logic signed [mbdft_pkg::TERM_W-1:0] re_s3, im_s3;
	logic signed [mbdft_pkg::ACC_W-1:0]  re_q, im_q;

	logic [1:0]   squad, cquad;
	logic [B-1:0] ph_idx;
	logic [B:0]   s_addr, c_addr;
	logic signed [15:0] cs_v, nsn_v;
	logic signed [64:0] re_p, im_p;
	logic signed [mbdft_pkg::ACC_W+6:0] re_sum, im_sum;

	always_ff @(posedge clk) begin
		if (ld_en)
			freq_q <= ld_freq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			tok_q <= tok_in;
			v_s1  <= tok_in.valid && act;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
		end
	end
	assign tok_out = tok_q;

	// phase = freq * t, wrapping in turns
	always_ff @(posedge clk) begin
		ph_s1 <= 32'(freq_q * tok_in.t);
		q_s1  <= tok_in.q;
	end

	// cosine is the sine one quadrant ahead
	assign squad  = ph_s1[31:30];
	assign cquad  = squad + 2'd1;
	assign ph_idx = ph_s1[29 -: B];
	assign s_addr = squad[0] ? ((B+1)'(mbdft_pkg::QUARTER_LEN) - {1'b0, ph_idx})
		: {1'b0, ph_idx};
	assign c_addr = cquad[0] ? ((B+1)'(mbdft_pkg::QUARTER_LEN) - {1'b0, ph_idx})
		: {1'b0, ph_idx};

	always_ff @(posedge clk) begin
		smag_s2 <= mbdft_pkg::SINE_TAB[s_addr];
		cmag_s2 <= mbdft_pkg::SINE_TAB[c_addr];
		sneg_s2 <= squad[1];
		cneg_s2 <= cquad[1];
		q_s2    <= q_s1;
	end

	assign cs_v  = cneg_s2 ? -$signed({1'b0, cmag_s2}) : $signed({1'b0, cmag_s2});
	assign nsn_v = sneg_s2 ? $signed({1'b0, smag_s2}) : -$signed({1'b0, smag_s2});
	assign re_p  = q_s2 * cs_v + 65'sd1024;
	assign im_p  = q_s2 * nsn_v + 65'sd1024;

	always_ff @(posedge clk) begin
		re_s3 <= re_p[64:11];
		im_s3 <= im_p[64:11];
	end

	assign re_sum = (mbdft_pkg::ACC_W+7)'(re_q) + (mbdft_pkg::ACC_W+7)'(re_s3);
	assign im_sum = (mbdft_pkg::ACC_W+7)'(im_q) + (mbdft_pkg::ACC_W+7)'(im_s3);

	function automatic logic signed [mbdft_pkg::ACC_W-1:0] sat_acc(
		input logic signed [mbdft_pkg::ACC_W+6:0] v);
		logic [7:0] top;
		top = v[mbdft_pkg::ACC_W+6 -: 8];
		if (top == 8'h00 || top == 8'hFF)
			return v[mbdft_pkg::ACC_W-1:0];
		return v[mbdft_pkg::ACC_W+6] ? {1'b1, {(mbdft_pkg::ACC_W-1){1'b0}}}
			: {1'b0, {(mbdft_pkg::ACC_W-1){1'b1}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			re_q <= '0;
			im_q <= '0;
		end else if (clr) begin
			re_q <= '0;
			im_q <= '0;
		end else if (v_s3) begin
			re_q <= sat_acc(re_sum);
			im_q <= sat_acc(im_sum);
		end
	end

	assign acc_re = re_q;
	assign acc_im = im_q;

endmodule
`default_nettype wire

>>> design/multi_bin_dft_accumulator.sv
// Top level: item control, remainder units, bin cell chain and result register
`timescale 1ns / 1ps
`default_nettype none
// Multi-bin running DFT accumulator. Items arrive on the in_* channel and results
// leave on the out_* channel, both valid/stall. A load item writes one frequency
// word, a clear item zeroes all bins. A read item moves to the read state, which
// loads the bin's complex accumulator into the result register once that register
// is not holding a stalled result.
// A sample item (when enabled) first runs two bit-serial remainder units that
// test the step count against both intervals. If the time-domain period hits, the
// weighted sample is emitted. If the frequency period hits, a token carrying the
// scaled sample walks a chain of NUM_FREQ cells, one bin per cycle; each of the
// first CFG_NUM_FREQS cells rotates it by its own phase and adds it into its
// saturating accumulator. The sequencer then waits in its drain state while the
// chain empties. The emit waits while the result register is stalled. The result
// register lets a new item in while a result waits.
module multi_bin_dft_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	// items in
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [3:0]         bin_index,
	input  logic [31:0]        freq_step,
	input  logic signed [31:0] sample_value,
	input  logic [31:0]        sample_time,
	input  logic [31:0]        step_count,
	// results out
	output logic               out_valid,
	input  logic               out_stall,
	output logic               out_kind,
	output logic [31:0]        out_time,
	output logic signed [31:0] weighted_value,
	output logic [3:0]         out_bin,
	output logic signed [47:0] bin_real,
	output logic signed [47:0] bin_imag
);

`include "multi_bin_dft_accumulator_defines.svh"

	localparam int NF = mbdft_pkg::NUM_FREQ;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_READ   = 6'b000010,
		S_DIV    = 6'b000100,
		S_EMIT   = 6'b001000,
		S_LAUNCH = 6'b010000,
		S_DRAIN  = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic               enable_q;
	logic signed [15:0] weight_q;
	logic [15:0]        td_intvl_q;
	logic [15:0]        fd_intvl_q;
	logic [15:0]        scale_q;
	logic [4:0]         nfreq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			weight_q   <= 16'sd4096;
			td_intvl_q <= '0;
			fd_intvl_q <= '0;
			scale_q    <= '0;
			nfreq_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mbdft_pkg::CFG_ENABLE:    enable_q   <= cfg_wdata[0];
				mbdft_pkg::CFG_WEIGHT:    weight_q   <= $signed(cfg_wdata);
				mbdft_pkg::CFG_TD_INTVL:  td_intvl_q <= cfg_wdata;
				mbdft_pkg::CFG_FD_INTVL:  fd_intvl_q <= cfg_wdata;
				mbdft_pkg::CFG_BIN_SCALE: scale_q    <= cfg_wdata;
				mbdft_pkg::CFG_NUM_FREQS: nfreq_q    <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// item acceptance and decode
	logic in_take;
	logic is_load, is_sample, is_read, is_clear;

	assign in_stall     = (state_q != S_IDLE);
	assign in_take      = in_valid && !in_stall;
	assign is_load      = (kind == mbdft_pkg::KIND_LOAD);
	assign is_sample    = (kind == mbdft_pkg::KIND_SAMPLE);
	assign is_read      = (kind == mbdft_pkg::KIND_READ);
	assign is_clear     = (kind == mbdft_pkg::KIND_CLEAR);

	logic mod_start;
	assign mod_start = in_take && is_sample && enable_q;

	// hold the item's operands for the rest of its work
	logic [3:0]         bin_q;
	logic [31:0]        time_q;
	logic signed [47:0] p_q;
	logic signed [mbdft_pkg::QW-1:0] q_q;
	logic               fd_hit_q;
	logic signed [64:0] qp;

	assign qp = p_q * $signed({1'b0, scale_q});

	always_ff @(posedge clk) begin
		if (in_take) begin
			bin_q  <= bin_index;
			time_q <= sample_time;
			p_q    <= sample_value * weight_q;
		end
		q_q <= qp[64:16];
	end

	// step count remainders for both periods
	logic        td_done, fd_done;
	logic [15:0] td_rem, fd_rem;
	logic        td_hit, fd_hit;

	mbdft_mod u_td_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (step_count),
		.divisor  (td_intvl_q),
		.done     (td_done),
		.rem      (td_rem)
	);

	mbdft_mod u_fd_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (step_count),
		.divisor  (fd_intvl_q),
		.done     (fd_done),
		.rem      (fd_rem)
	);

	assign td_hit = (td_intvl_q != 16'd0) && (td_rem == 16'd0);
	assign fd_hit = (fd_intvl_q != 16'd0) && (fd_rem == 16'd0);

	// cell chain
	mbdft_pkg::tok_t tok_chain [0:NF];
	logic signed [47:0] acc_re_w [0:NF-1];
	logic signed [47:0] acc_im_w [0:NF-1];
	logic               clr_all;

	assign clr_all            = in_take && is_clear;
	assign tok_chain[0].valid = (state_q == S_LAUNCH);
	assign tok_chain[0].q     = q_q;
	assign tok_chain[0].t     = time_q;

	for (genvar i = 0; i < NF; i++) begin : g_cell
		logic act;
		logic ld;
		assign act = (i < 32'(nfreq_q));
		assign ld  = in_take && is_load && (32'(bin_index) == i);
		mbdft_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.act     (act),
			.ld_en   (ld),
			.ld_freq (freq_step),
			.clr     (clr_all),
			.tok_in  (tok_chain[i]),
			.tok_out (tok_chain[i+1]),
			.acc_re  (acc_re_w[i]),
			.acc_im  (acc_im_w[i])
		);
	end

	// result register
	logic out_free;
	logic ld_read, ld_td;
	logic out_valid_q;
	logic signed [48:0] wsum;
	logic signed [36:0] wv37;
	logic signed [31:0] wv_sat;
	logic [mbdft_pkg::IDX_W-1:0] rd_idx;

	assign out_free = !out_valid_q || !out_stall;
	assign ld_read  = (state_q == S_READ) && out_free;
	assign ld_td    = (state_q == S_EMIT) && out_free;
	assign wsum     = 49'(p_q) + 49'sd2048;
	assign wv37     = wsum[48:12];
	assign wv_sat   = (wv37[36:31] == 6'h00 || wv37[36:31] == 6'h3F) ? wv37[31:0]
		: (wv37[36] ? 32'sh80000000 : 32'sh7FFFFFFF);
	assign rd_idx   = bin_q[mbdft_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld_read || ld_td)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_read) begin
			out_kind       <= mbdft_pkg::OUT_BIN;
			out_time       <= '0;
			weighted_value <= '0;
			out_bin        <= bin_q;
			bin_real       <= (32'(bin_q) < NF) ? acc_re_w[rd_idx] : '0;
			bin_imag       <= (32'(bin_q) < NF) ? acc_im_w[rd_idx] : '0;
		end else if (ld_td) begin
			out_kind       <= mbdft_pkg::OUT_TD;
			out_time       <= time_q;
			weighted_value <= wv_sat;
			out_bin        <= '0;
			bin_real       <= '0;
			bin_imag       <= '0;
		end
	end

	assign out_valid = out_valid_q;

	// sequencer
	logic [mbdft_pkg::DRAIN_W-1:0] drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			drain_q  <= '0;
			fd_hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_take && is_read)
						state_q <= S_READ;
					else if (mod_start)
						state_q <= S_DIV;
				end
				S_READ: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_DIV: begin
					if (td_done && fd_done) begin
						fd_hit_q <= fd_hit;
						if (td_hit)
							state_q <= S_EMIT;
						else if (fd_hit)
							state_q <= S_LAUNCH;
						else
							state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free)
						state_q <= fd_hit_q ? S_LAUNCH : S_IDLE;
				end
				S_LAUNCH: begin
					drain_q <= mbdft_pkg::DRAIN_W'(NF + mbdft_pkg::CELL_LAT);
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (drain_q == '0)
						state_q <= S_IDLE;
					else
						drain_q <= drain_q - 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// both remainder units run in lockstep
	`MBDFT_ASSERT(a_mod_lockstep, td_done == fd_done)
	// a time-domain result is loaded when emitted
	`MBDFT_ASSERT(a_emit_loads, ld_td |=> out_valid_q && out_kind == mbdft_pkg::OUT_TD)
	// a read item yields a bin readout
	`MBDFT_ASSERT(a_read_loads, ld_read |=> out_valid_q && out_kind == mbdft_pkg::OUT_BIN)
	// the token leaves the chain before the sweep ends
	`MBDFT_ASSERT(a_tok_in_drain, tok_chain[NF].valid |-> state_q == S_DRAIN)

endmodule
`default_nettype wire

>>> bench/multi_bin_dft_accumulator_check.sv
// Checker: watches the item channels, predicts the DFT accumulator and compares results
`timescale 1ns / 1ps
module multi_bin_dft_accumulator_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [3:0]         bin_index,
	input  logic [31:0]        freq_step,
	input  logic signed [31:0] sample_value,
	input  logic [31:0]        sample_time,
	input  logic [31:0]        step_count,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               out_kind,
	input  logic [31:0]        out_time,
	input  logic signed [31:0] weighted_value,
	input  logic [3:0]         out_bin,
	input  logic signed [47:0] bin_real,
	input  logic signed [47:0] bin_imag,
	output int                 fail_count,
	output int                 pending
);

	typedef struct {
		logic        okind;
		logic [31:0] otime;
		logic [31:0] wval;
		logic [3:0]  obin;
		logic [47:0] re;
		logic [47:0] im;
	} dft_result_t;

	localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	int          quarter_wave [0:mbdft_pkg::QUARTER_LEN];
	logic [31:0] freq_words [mbdft_pkg::NUM_FREQ];
	longint      acc_re [mbdft_pkg::NUM_FREQ];
	longint      acc_im [mbdft_pkg::NUM_FREQ];
	logic        en_q;
	longint      weight_q;
	int unsigned td_q, fd_q, scale_q, nfreq_q;
	dft_result_t expected_results [$];

	function automatic int taylor_sine(int k);
		longint unsigned x, x2, term;
		longint          sum, r;
		x    = (longint'(k) * 64'd1686629713) >> mbdft_pkg::SINE_TABLE_BITS;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			sum  = (n % 2) ? sum - longint'(term) : sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		r = (sum + 16384) >>> 15;
		return (r > 32767) ? 32767 : int'(r);
	endfunction

	function automatic longint sine_of_turn(logic [31:0] ph);
		int i, v;
		i = int'(ph[29:30-mbdft_pkg::SINE_TABLE_BITS]);
		v = ph[30] ? quarter_wave[mbdft_pkg::QUARTER_LEN - i] : quarter_wave[i];
		return ph[31] ? -longint'(v) : longint'(v);
	endfunction

	function automatic longint clamp48(longint v);
		if (v > ACC_MAX)
			return ACC_MAX;
		if (v < ACC_MIN)
			return ACC_MIN;
		return v;
	endfunction

	// Queue one expected result at the back
	task automatic add_expected(dft_result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic reset_model();
		for (int n = 0; n < mbdft_pkg::NUM_FREQ; n++) begin
			freq_words[n] = '0;
			acc_re[n] = 0;
			acc_im[n] = 0;
		end
		en_q = 1'b0;
		weight_q = 4096;
		td_q = 0;
		fd_q = 0;
		scale_q = 0;
		nfreq_q = 0;
		expected_results.delete();
	endtask

	// Advance the model by one accepted item
	task automatic predict_item();
		dft_result_t r;
		longint      p, q, wv, sn, cs;
		logic [31:0] ph;
		int          nb;
		r = '{default: '0};
		case (mbdft_pkg::kind_t'(kind))
			mbdft_pkg::KIND_LOAD: freq_words[bin_index] = freq_step;
			mbdft_pkg::KIND_CLEAR: begin
				for (int n = 0; n < mbdft_pkg::NUM_FREQ; n++) begin
					acc_re[n] = 0;
					acc_im[n] = 0;
				end
			end
			mbdft_pkg::KIND_READ: begin
				r.okind = mbdft_pkg::OUT_BIN;
				r.obin = bin_index;
				r.re = acc_re[bin_index][47:0];
				r.im = acc_im[bin_index][47:0];
				add_expected(r);
			end
			default: begin
				if (en_q) begin
					p = longint'(sample_value) * weight_q;
					if (td_q != 0 && step_count % td_q == 0) begin
						wv = (p + 2048) >>> 12;
						if (wv > 64'sd2147483647)
							wv = 64'sd2147483647;
						if (wv < -64'sd2147483648)
							wv = -64'sd2147483648;
						r.okind = mbdft_pkg::OUT_TD;
						r.otime = sample_time;
						r.wval = wv[31:0];
						add_expected(r);
					end
					if (fd_q != 0 && step_count % fd_q == 0) begin
						nb = (nfreq_q < mbdft_pkg::NUM_FREQ) ? nfreq_q : mbdft_pkg::NUM_FREQ;
						q = (p * longint'(scale_q)) >>> 16;
						for (int n = 0; n < nb; n++) begin
							ph = freq_words[n] * sample_time;
							sn = sine_of_turn(ph);
							cs = sine_of_turn(ph + 32'h4000_0000);
							acc_re[n] = clamp48(acc_re[n] + ((q * cs + 1024) >>> 11));
							acc_im[n] = clamp48(acc_im[n] + ((q * -sn + 1024) >>> 11));
						end
					end
				end
			end
		endcase
	endtask

	task automatic compare_result();
		dft_result_t e;
		if (expected_results.size() == 0) begin
			$error("unexpected result: kind %0d", out_kind);
			fail_count++;
			return;
		end
		e = expected_results.pop_front();
		if (out_kind !== e.okind) begin
			$error("out_kind: expected %0d, got %0d", e.okind, out_kind);
			fail_count++;
		end
		if (out_time !== e.otime) begin
			$error("out_time: expected %0d, got %0d", e.otime, out_time);
			fail_count++;
		end
		if (weighted_value !== e.wval) begin
			$error("weighted_value: expected %0d, got %0d", $signed(e.wval), weighted_value);
			fail_count++;
		end
		if (out_bin !== e.obin) begin
			$error("out_bin: expected %0d, got %0d", e.obin, out_bin);
			fail_count++;
		end
		if (bin_real !== e.re) begin
			$error("bin_real: expected %0d, got %0d", $signed(e.re), bin_real);
			fail_count++;
		end
		if (bin_imag !== e.im) begin
			$error("bin_imag: expected %0d, got %0d", $signed(e.im), bin_imag);
			fail_count++;
		end
	endtask

	initial begin
		for (int k = 0; k <= mbdft_pkg::QUARTER_LEN; k++)
			quarter_wave[k] = taylor_sine(k);
		fail_count = 0;
		pending = 0;
		reset_model();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			pending = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				predict_item();
			if (cfg_wr_en) begin
				case (cfg_index)
					mbdft_pkg::CFG_ENABLE:    en_q = cfg_wdata[0];
					mbdft_pkg::CFG_WEIGHT:    weight_q = longint'($signed(cfg_wdata));
					mbdft_pkg::CFG_TD_INTVL:  td_q = cfg_wdata;
					mbdft_pkg::CFG_FD_INTVL:  fd_q = cfg_wdata;
					mbdft_pkg::CFG_BIN_SCALE: scale_q = cfg_wdata;
					mbdft_pkg::CFG_NUM_FREQS: nfreq_q = cfg_wdata[4:0];
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> bench/multi_bin_dft_accumulator_test.sv
// Testbench top: clock, reset, stimulus and verdict for the multi-bin DFT accumulator
`timescale 1ns / 1ps
module multi_bin_dft_accumulator_test;

	// Longest item without a result: remainder units plus the full cell chain drain
	localparam int DRAIN_CYCLES = 120;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 100;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_wdata;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic [3:0]         bin_index;
	logic [31:0]        freq_step;
	logic signed [31:0] sample_value;
	logic [31:0]        sample_time;
	logic [31:0]        step_count;
	logic               out_valid;
	logic               out_stall;
	logic               out_kind;
	logic [31:0]        out_time;
	logic signed [31:0] weighted_value;
	logic [3:0]         out_bin;
	logic signed [47:0] bin_real;
	logic signed [47:0] bin_imag;
	int                 fail_count;
	int                 pending;

	// Stimulus-side copies of the intervals, used to aim step counts at hits
	int unsigned td_now, fd_now;
	// Turn off both sides' idling for a stretch
	bit          steady;
	int          out_hold;

	multi_bin_dft_accumulator dut (.*);

	multi_bin_dft_accumulator_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int draw_gap();
		if (steady || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// Receiver: after each accepted result, stall for a drawn number of cycles
	initial begin
		out_stall = 1'b0;
		out_hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				out_hold = draw_gap();
			if (out_hold > 0) begin
				out_stall <= 1'b1;
				out_hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == mbdft_pkg::CFG_TD_INTVL)
			td_now = data;
		if (idx == mbdft_pkg::CFG_FD_INTVL)
			fd_now = data;
	endtask

	// Hold the item until accepted, then drop valid for the drawn gap
	task automatic send_item(mbdft_pkg::kind_t k, logic [3:0] b, logic [31:0] f,
			logic [31:0] s, logic [31:0] t, logic [31:0] st);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		bin_index <= b;
		freq_step <= f;
		sample_value <= s;
		sample_time <= t;
		step_count <= st;
		do @(posedge clk); while (in_stall);
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every result is back and the cell chain has drained
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] aim_step();
		longint unsigned span;
		case ($urandom_range(0, 3))
			0: span = td_now;
			1: span = fd_now;
			2: span = longint'(td_now) * fd_now;
			default: return $urandom;
		endcase
		if (span == 0 || span > 64'hFFFF_FFFF)
			return $urandom;
		return 32'(span * $urandom_range(0, 32'(64'hFFFF_FFFF / span)));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 131071)) - 32'd65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_interval(int ph);
		case (ph % 4)
			0: return 16'd1;
			1: return 16'($urandom_range(2, 6));
			2: return 16'hFFFF;
			default: return 16'd0;
		endcase
	endfunction

	initial begin
		int          roll;
		logic [15:0] wsel [4];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		kind = mbdft_pkg::KIND_LOAD;
		bin_index = '0;
		freq_step = '0;
		sample_value = '0;
		sample_time = '0;
		step_count = '0;
		td_now = 0;
		fd_now = 0;
		steady = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full-scale settings, every bin loaded before any accumulation
		write_reg(mbdft_pkg::CFG_ENABLE, 16'd1);
		write_reg(mbdft_pkg::CFG_WEIGHT, 16'h7FFF);
		write_reg(mbdft_pkg::CFG_TD_INTVL, 16'd1);
		write_reg(mbdft_pkg::CFG_FD_INTVL, 16'd1);
		write_reg(mbdft_pkg::CFG_BIN_SCALE, 16'hFFFF);
		write_reg(mbdft_pkg::CFG_NUM_FREQS, 16'd16);
		for (int n = 0; n < mbdft_pkg::NUM_FREQ; n++)
			send_item(mbdft_pkg::KIND_LOAD, 4'(n), (n == 0) ? 32'h0 :
				(n == 1) ? 32'hFFFF_FFFF : (n == 2) ? 32'h4000_0000 : $urandom,
				$urandom, $urandom, $urandom);
		send_item(mbdft_pkg::KIND_SAMPLE, 4'd0, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_item(mbdft_pkg::KIND_SAMPLE, 4'd15, 32'd0, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);
		// Repeated full-scale samples drive the accumulators into saturation
		repeat (3)
			send_item(mbdft_pkg::KIND_SAMPLE, 4'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd7);
		send_item(mbdft_pkg::KIND_READ, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(mbdft_pkg::KIND_READ, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(mbdft_pkg::KIND_CLEAR, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		send_item(mbdft_pkg::KIND_READ, 4'd3, 32'd0, 32'd0, 32'd0, 32'd0);
		quiesce();

		// Random phases, each with its own setting; phase 2 runs disabled
		wsel = '{16'h8000, 16'h7FFF, 16'd4096, 16'd0};
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(mbdft_pkg::CFG_ENABLE, (ph == 2) ? 16'd0 : 16'd1);
			write_reg(mbdft_pkg::CFG_WEIGHT, (ph < 4) ? wsel[ph] : 16'($urandom));
			write_reg(mbdft_pkg::CFG_TD_INTVL, pick_interval(ph));
			write_reg(mbdft_pkg::CFG_FD_INTVL, pick_interval(ph + 1));
			write_reg(mbdft_pkg::CFG_BIN_SCALE, (ph % 3 == 0) ? 16'hFFFF :
				(ph % 3 == 1) ? 16'd0 : 16'($urandom));
			write_reg(mbdft_pkg::CFG_NUM_FREQS, (ph == 1) ? 16'd0 : (ph == 5) ? 16'd16 :
				16'($urandom_range(1, 16)));
			steady = (ph == 4);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				roll = $urandom_range(0, 99);
				if (i == ITEMS_PER_PHASE / 2) begin
					// Let every outstanding result drain before going on
					in_valid <= 1'b0;
					@(posedge clk);
					wait (pending == 0);
					@(posedge clk);
				end
				if (roll < 60)
					send_item(mbdft_pkg::KIND_SAMPLE, 4'($urandom), $urandom, pick_value(),
						$urandom, aim_step());
				else if (roll < 85)
					send_item(mbdft_pkg::KIND_READ, 4'($urandom), $urandom, $urandom,
						$urandom, $urandom);
				else if (roll < 96)
					send_item(mbdft_pkg::KIND_LOAD, 4'($urandom), $urandom, $urandom,
						$urandom, $urandom);
				else
					send_item(mbdft_pkg::KIND_CLEAR, 4'($urandom), $urandom, $urandom,
						$urandom, $urandom);
			end
			quiesce();
		end

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/mbdft_pkg.sv
design/mbdft_mod.sv
design/mbdft_cell.sv
design/multi_bin_dft_accumulator.sv
bench/multi_bin_dft_accumulator_check.sv
bench/multi_bin_dft_accumulator_test.sv
